// ===== hw/rtl/rdbt_pkg.sv =====
// Shared types and constants for the route discovery back-off table.
package rdbt_pkg;

    localparam logic [1:0] CMD_DISCOVER = 2'd0;
    localparam logic [1:0] CMD_REPLY    = 2'd1;
    localparam logic [1:0] CMD_SCAN     = 2'd2;
    localparam logic [1:0] CMD_CLEANUP  = 2'd3;

    localparam logic [2:0] ST_SEND     = 3'd0;
    localparam logic [2:0] ST_WAIT     = 3'd1;
    localparam logic [2:0] ST_MAX      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    localparam logic [1:0] REG_MAX_RETRIES = 2'd0;
    localparam logic [1:0] REG_RING_EN     = 2'd1;
    localparam logic [1:0] REG_INIT_TMO    = 2'd2;
    localparam logic [1:0] REG_IDLE_AGE    = 2'd3;

    localparam logic [7:0] HOP_RING_TOP = 8'd128;
    localparam logic [7:0] HOP_MAX      = 8'd255;

    // Command handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] dest_addr;
        logic [31:0] now_time;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  max_retries;
        logic        ring_en;
        logic [15:0] init_tmo;
        logic [31:0] idle_age;
    } cfg_t;

endpackage

// ===== hw/rtl/rdbt_front.sv =====
// Front end: accepts commands and queues them for the table engine.
module rdbt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        command,
    input  logic [47:0]       dest_addr,
    input  logic [31:0]       now_time,
    output logic              busy,
    output logic              q_valid,
    output rdbt_pkg::cmd_t    q_data,
    input  logic              q_pop
);

    // Two-entry queue; busy when full.
    rdbt_pkg::cmd_t slot_reg [2];
    logic           rd_ptr_reg;
    logic           wr_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{command: command, dest_addr: dest_addr,
                                      now_time: now_time};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ===== hw/rtl/rdbt_engine.sv =====
// Back end: walks the destination table and produces the results of each command.
module rdbt_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rdbt_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  rdbt_pkg::cmd_t    q_data,
    output logic              q_pop,
    output logic              res_valid,
    output logic [2:0]        status,
    output logic [47:0]       out_addr,
    output logic [7:0]        hop_limit,
    output logic [4:0]        removed_count,
    output logic              last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    rdbt_pkg::cmd_t  cmd_reg;
    logic [CW-1:0]   idx_reg;
    logic [IW-1:0]   hit_reg;
    logic            hit_found_reg;
    logic [IW-1:0]   free_reg;
    logic            free_found_reg;
    logic [4:0]      removed_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [47:0] addr_mem   [TABLE_DEPTH];
    logic [3:0]  cnt_mem    [TABLE_DEPTH];
    logic [7:0]  hop_mem    [TABLE_DEPTH];
    logic        act_mem    [TABLE_DEPTH];
    logic [31:0] dl_mem     [TABLE_DEPTH];
    logic [31:0] lu_mem     [TABLE_DEPTH];

    logic [IW-1:0] idx;
    logic [IW-1:0] ev_i;
    assign idx = idx_reg[IW-1:0];

    // Evaluation of one entry.
    logic [3:0]  e_cnt;
    logic [7:0]  e_hop, e_hop_new;
    logic [31:0] e_dl;
    logic [2:0]  e_st;
    logic [47:0] e_shift;
    logic [32:0] e_sum;
    logic [31:0] e_dl_new;
    logic        e_fresh;

    // A discover that allocates a slot evaluates an all-zero entry.
    assign e_fresh = (cmd_reg.command == rdbt_pkg::CMD_DISCOVER) && !hit_found_reg;

    always_comb
    begin
        e_cnt = e_fresh ? 4'd0 : cnt_mem[ev_i];
        e_hop = e_fresh ? 8'd0 : hop_mem[ev_i];
        e_dl  = e_fresh ? 32'd0 : dl_mem[ev_i];
        if (cmd_reg.now_time < e_dl)
            e_st = rdbt_pkg::ST_WAIT;
        else if ({1'b0, e_cnt} == {1'b0, cfg.max_retries} + 5'd1 || e_cnt == 4'd15)
            e_st = rdbt_pkg::ST_MAX;
        else
            e_st = rdbt_pkg::ST_SEND;
        if (!cfg.ring_en)
            e_hop_new = rdbt_pkg::HOP_MAX;
        else if (e_hop == 8'd0)
            e_hop_new = 8'd1;
        else if (e_hop == rdbt_pkg::HOP_RING_TOP)
            e_hop_new = rdbt_pkg::HOP_MAX;
        else if (e_hop != rdbt_pkg::HOP_MAX)
            e_hop_new = {e_hop[6:0], 1'b0};
        else
            e_hop_new = e_hop;
        e_shift = {32'd0, cfg.init_tmo} << e_cnt;
        e_sum = {1'b0, cmd_reg.now_time} + {1'b0, e_shift[31:0]};
        if (e_shift[47:32] != 16'd0)
            e_dl_new = 32'hFFFF_FFFF;
        else
            e_dl_new = e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];
    end

    // Discover and reply evaluate the found or allocated slot; scan walks idx.
    logic [IW-1:0] sel_i;
    assign sel_i = hit_found_reg ? hit_reg : free_reg;
    assign ev_i  = (cmd_reg.command == rdbt_pkg::CMD_SCAN) ? idx : sel_i;

    logic [32:0] idle_sum;
    logic        walk_end;
    assign idle_sum = {1'b0, lu_mem[idx]} + {1'b0, cfg.idle_age};
    assign walk_end = (idx_reg == CW'(TABLE_DEPTH - 1));

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (q_valid) state_next = S_SEARCH;
            S_SEARCH: if (walk_end)
                          state_next = (cmd_reg.command == rdbt_pkg::CMD_DISCOVER) ?
                                       S_EVAL : S_FINISH;
            S_EVAL:   state_next = S_IDLE;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            res_valid      <= 1'b0;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            removed_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg        <= '0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    removed_reg    <= '0;
                end
                S_SEARCH:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    case (cmd_reg.command)
                        rdbt_pkg::CMD_DISCOVER, rdbt_pkg::CMD_REPLY:
                        begin
                            if (valid_reg[idx] && addr_mem[idx] == cmd_reg.dest_addr
                                && !hit_found_reg)
                            begin
                                hit_found_reg <= 1'b1;
                                hit_reg       <= idx;
                            end
                            if (!valid_reg[idx] && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_reg       <= idx;
                            end
                        end
                        rdbt_pkg::CMD_CLEANUP:
                        begin
                            if (valid_reg[idx] && {1'b0, cmd_reg.now_time} >= idle_sum)
                            begin
                                valid_reg[idx] <= 1'b0;
                                if (removed_reg != 5'd31)
                                    removed_reg <= removed_reg + 5'd1;
                            end
                        end
                        default:
                        begin
                            if (valid_reg[idx] && act_mem[idx] && e_st == rdbt_pkg::ST_SEND)
                            begin
                                res_valid     <= 1'b1;
                                status        <= rdbt_pkg::ST_SEND;
                                out_addr      <= addr_mem[idx];
                                hop_limit     <= e_hop_new;
                                removed_count <= '0;
                                last          <= 1'b0;
                            end
                        end
                    endcase
                end
                S_EVAL:
                begin
                    res_valid     <= 1'b1;
                    out_addr      <= cmd_reg.dest_addr;
                    removed_count <= '0;
                    last          <= 1'b1;
                    if (!hit_found_reg && !free_found_reg)
                    begin
                        status    <= rdbt_pkg::ST_FULL;
                        hop_limit <= '0;
                    end
                    else
                    begin
                        valid_reg[sel_i] <= 1'b1;
                        status    <= e_st;
                        hop_limit <= (e_st == rdbt_pkg::ST_SEND) ? e_hop_new : 8'd0;
                    end
                end
                S_FINISH:
                begin
                    res_valid     <= 1'b1;
                    hop_limit     <= '0;
                    last          <= 1'b1;
                    removed_count <= (cmd_reg.command == rdbt_pkg::CMD_CLEANUP) ?
                                     removed_reg : 5'd0;
                    if (cmd_reg.command == rdbt_pkg::CMD_REPLY)
                    begin
                        out_addr <= cmd_reg.dest_addr;
                        status   <= hit_found_reg ? rdbt_pkg::ST_DONE : rdbt_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        out_addr <= '0;
                        status   <= rdbt_pkg::ST_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Table payload and command register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_data;
        if (state_reg == S_SEARCH && cmd_reg.command == rdbt_pkg::CMD_SCAN
            && valid_reg[idx] && act_mem[idx])
        begin
            lu_mem[idx] <= cmd_reg.now_time;
            if (e_st == rdbt_pkg::ST_SEND)
            begin
                hop_mem[idx] <= e_hop_new;
                dl_mem[idx]  <= e_dl_new;
                cnt_mem[idx] <= e_cnt + 4'd1;
                act_mem[idx] <= 1'b1;
            end
            else if (e_st == rdbt_pkg::ST_MAX)
            begin
                hop_mem[idx] <= '0;
                dl_mem[idx]  <= '0;
                cnt_mem[idx] <= '0;
                act_mem[idx] <= 1'b0;
            end
        end
        if (state_reg == S_FINISH && cmd_reg.command == rdbt_pkg::CMD_REPLY && hit_found_reg)
        begin
            hop_mem[hit_reg] <= '0;
            dl_mem[hit_reg]  <= '0;
            cnt_mem[hit_reg] <= '0;
            act_mem[hit_reg] <= 1'b0;
        end
        if (state_reg == S_EVAL && (hit_found_reg || free_found_reg))
        begin
            lu_mem[sel_i] <= cmd_reg.now_time;
            if (!hit_found_reg)
            begin
                // Fresh slot: an all-zero entry always passes the deadline.
                addr_mem[sel_i] <= cmd_reg.dest_addr;
                if ({1'b0, cfg.max_retries} + 5'd1 == 5'd0)
                    act_mem[sel_i] <= 1'b0;
                else
                begin
                    hop_mem[sel_i] <= cfg.ring_en ? 8'd1 : rdbt_pkg::HOP_MAX;
                    dl_mem[sel_i]  <= e_dl_new;
                    cnt_mem[sel_i] <= 4'd1;
                    act_mem[sel_i] <= 1'b1;
                end
            end
            else if (e_st == rdbt_pkg::ST_SEND)
            begin
                hop_mem[sel_i] <= e_hop_new;
                dl_mem[sel_i]  <= e_dl_new;
                cnt_mem[sel_i] <= e_cnt + 4'd1;
                act_mem[sel_i] <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/route_discovery_backoff_table.sv =====
// Top level of the route discovery back-off table.
// A command passes the two-entry queue and the table walk in S_SEARCH; then S_EVAL or
// S_FINISH registers its last result. Scan sends come at most one per cycle in the walk.
// The engine walks the table one entry per cycle and takes a new command only in S_IDLE,
// once done with the previous one; a two-entry queue decouples start from the engine.
// Results are one-cycle strobes, the receiver cannot stall; reset clears all entries.
module route_discovery_backoff_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [47:0] dest_addr,
    input  logic [31:0] now_time,
    output logic        done,
    output logic [2:0]  status,
    output logic [47:0] out_addr,
    output logic [7:0]  hop_limit,
    output logic [4:0]  removed_count,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rdbt_pkg::cfg_t cfg_reg;
    rdbt_pkg::cmd_t q_data;
    logic           q_valid;
    logic           q_pop;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_retries <= 4'd2;
            cfg_reg.ring_en     <= 1'b1;
            cfg_reg.init_tmo    <= 16'd500;
            cfg_reg.idle_age    <= 32'd60000;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                rdbt_pkg::REG_MAX_RETRIES: cfg_reg.max_retries <= pwdata[3:0];
                rdbt_pkg::REG_RING_EN:     cfg_reg.ring_en     <= pwdata[0];
                rdbt_pkg::REG_INIT_TMO:    cfg_reg.init_tmo    <= pwdata[15:0];
                rdbt_pkg::REG_IDLE_AGE:    cfg_reg.idle_age    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rdbt_pkg::REG_MAX_RETRIES: prdata = {28'd0, cfg_reg.max_retries};
            rdbt_pkg::REG_RING_EN:     prdata = {31'd0, cfg_reg.ring_en};
            rdbt_pkg::REG_INIT_TMO:    prdata = {16'd0, cfg_reg.init_tmo};
            rdbt_pkg::REG_IDLE_AGE:    prdata = cfg_reg.idle_age;
            default:                   prdata = '0;
        endcase
    end

    rdbt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .dest_addr (dest_addr),
        .now_time  (now_time),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    rdbt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .res_valid     (done),
        .status        (status),
        .out_addr      (out_addr),
        .hop_limit     (hop_limit),
        .removed_count (removed_count),
        .last          (last)
    );

endmodule
